// ===== design/bsf_pkg.sv =====
// Shared types, constants and helpers of the 3x3 binomial smoothing filter.
package bsf_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WIDTH_W      = 12;
    localparam int HEIGHT_W     = 13;
    localparam int ROW_W        = HEIGHT_W;
    localparam int CH_W         = 8;
    localparam int NUM_LANES    = 4;
    localparam int PIX_W        = CH_W * NUM_LANES;
    localparam int WIN_SIZE     = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int DIV_W        = 3;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // divisor codes: sum of the kernel weights left inside the image
    localparam logic [DIV_W-1:0] DIV16 = DIV_W'(0);
    localparam logic [DIV_W-1:0] DIV12 = DIV_W'(1);
    localparam logic [DIV_W-1:0] DIV9  = DIV_W'(2);
    localparam logic [DIV_W-1:0] DIV8  = DIV_W'(3);
    localparam logic [DIV_W-1:0] DIV6  = DIV_W'(4);
    localparam logic [DIV_W-1:0] DIV4  = DIV_W'(5);

    typedef struct packed {
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
    } bsf_edge_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             clr;
        logic             emit;
        logic             last;
        bsf_edge_t        edges;
    } bsf_item_t;

    // kernel is separable: weight sum = (1+2+1 masked) * (1+2+1 masked)
    function automatic logic [DIV_W-1:0] div_code(input bsf_edge_t e);
        logic [1:0] nc;
        logic [1:0] nr;
        logic [DIV_W-1:0] code;
        nc = 2'(e.left_ok) + 2'(e.right_ok);
        nr = 2'(e.top_ok) + 2'(e.bot_ok);
        case ({nc, nr})
            4'b10_10:          code = DIV16;
            4'b01_10, 4'b10_01: code = DIV12;
            4'b01_01:          code = DIV9;
            4'b00_10, 4'b10_00: code = DIV8;
            4'b00_01, 4'b01_00: code = DIV6;
            default:           code = DIV4;
        endcase
        return code;
    endfunction

endpackage

// ===== design/bsf_ctrl.sv =====
// Raster position counters, configuration registers and per-transfer decisions.
module bsf_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_xfer,
    input  logic                           opcode,
    input  logic [bsf_pkg::PIX_W-1:0]      pix,
    output logic                           take,
    output bsf_pkg::bsf_item_t             item
);
    import bsf_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    in_col_reg;
    logic [ROW_W-1:0]    in_row_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic                frame_done_reg;
    logic                clr_pend_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                restart;
    logic                drop;
    logic [COL_W-1:0]    ic;
    logic [ROW_W-1:0]    ir;
    logic [COL_W-1:0]    oc;
    logic [ROW_W-1:0]    orow;
    logic [WIDTH_W-1:0]  ic_inc;
    logic [WIDTH_W-1:0]  oc_inc;
    logic [ROW_W:0]      orow_inc;
    logic                in_wrap;
    logic                out_wrap;
    logic                bot_ok;
    logic                emit;

    always_comb begin
        w_eff = width_reg;
        if (width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (width_reg > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (height_reg > HEIGHT_W'(HEIGHT_LIMIT)) begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end
    end

    // a pixel after the last result opens the next image
    assign restart = frame_done_reg && (opcode == OP_PIXEL);
    assign drop    = frame_done_reg ? (opcode == OP_FLUSH)
                                    : ((in_row_reg < h_eff) && (opcode == OP_FLUSH));

    assign ic   = restart ? '0 : in_col_reg;
    assign ir   = restart ? '0 : in_row_reg;
    assign oc   = restart ? '0 : out_col_reg;
    assign orow = restart ? '0 : out_row_reg;

    assign ic_inc   = WIDTH_W'(ic) + WIDTH_W'(1);
    assign oc_inc   = WIDTH_W'(oc) + WIDTH_W'(1);
    assign orow_inc = {1'b0, orow} + (ROW_W+1)'(1);
    assign in_wrap  = ic_inc >= w_eff;
    assign out_wrap = oc_inc >= w_eff;
    assign bot_ok   = orow_inc < {1'b0, h_eff};
    assign emit     = (ir > ROW_W'(1)) || ((ir == ROW_W'(1)) && (ic != '0));

    assign take = in_xfer && !drop;

    always_comb begin
        item.col            = ic;
        item.pix            = (ir >= h_eff) ? '0 : pix;
        item.clr            = restart || clr_pend_reg;
        item.emit           = emit;
        item.last           = emit && out_wrap && !bot_ok;
        item.edges.left_ok  = oc != '0;
        item.edges.right_ok = !out_wrap;
        item.edges.top_ok   = orow != '0;
        item.edges.bot_ok   = bot_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= RESET_WIDTH;
            height_reg     <= RESET_HEIGHT;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            frame_done_reg <= 1'b0;
            clr_pend_reg   <= 1'b1;
        end else if (cfg_wr_en && ((cfg_index == REG_IMAGE_WIDTH) ||
                                   (cfg_index == REG_IMAGE_HEIGHT))) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_wdata[WIDTH_W-1:0];
            end else begin
                height_reg <= cfg_wdata[HEIGHT_W-1:0];
            end
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            frame_done_reg <= 1'b0;
            clr_pend_reg   <= 1'b1;
        end else if (take) begin
            in_col_reg   <= in_wrap ? '0 : ic_inc[COL_W-1:0];
            in_row_reg   <= ir + ROW_W'(in_wrap);
            clr_pend_reg <= 1'b0;
            if (emit) begin
                out_col_reg <= out_wrap ? '0 : oc_inc[COL_W-1:0];
                out_row_reg <= out_wrap ? orow_inc[ROW_W-1:0] : orow;
            end else begin
                out_col_reg <= oc;
                out_row_reg <= orow;
            end
            frame_done_reg <= item.last;
        end
    end

endmodule

// ===== design/bsf_line_store.sv =====
// Two-row line store: one word per column holds the pixels of the two rows above.
module bsf_line_store (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [bsf_pkg::COL_W-1:0]    rd_addr,
    input  logic                         wr_en,
    input  logic [bsf_pkg::COL_W-1:0]    wr_addr,
    input  logic [2*bsf_pkg::PIX_W-1:0]  wr_data,
    output logic [2*bsf_pkg::PIX_W-1:0]  rd_data
);
    import bsf_pkg::*;

    // [2*PIX_W-1:PIX_W] far row, [PIX_W-1:0] near row
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first on a same-column hit (one-pixel-wide images)
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bsf_lane.sv =====
// One colour channel: masked 3x3 weighted sum, then division by the weight sum.
module bsf_lane (
    input  logic                                          aclk,
    input  logic                                          en,
    input  logic [bsf_pkg::WIN_SIZE-1:0][bsf_pkg::CH_W-1:0] win,
    input  bsf_pkg::bsf_edge_t                            edges,
    input  logic [bsf_pkg::DIV_W-1:0]                     code,
    output logic [bsf_pkg::CH_W-1:0]                      quot
);
    import bsf_pkg::*;

    localparam int V_W      = CH_W + 2;
    localparam int S_W      = CH_W + 4;
    localparam int P_W      = 2 * S_W;
    localparam int DIV3_MUL = 2731;
    localparam int DIV3_SH  = 13;
    localparam int DIV9_MUL = 1821;
    localparam int DIV9_SH  = 14;

    logic [2:0][V_W-1:0] vsum;
    logic [S_W-1:0]      hsum;
    logic [S_W-1:0]      sum_reg;
    logic [P_W-1:0]      prod3_12;
    logic [P_W-1:0]      prod3_6;
    logic [P_W-1:0]      prod9;
    logic [S_W-1:0]      q;

    // vertical 1-2-1 per column slot, then horizontal 1-2-1
    always_comb begin
        for (int cs = 0; cs < 3; cs++) begin
            vsum[cs] = (edges.top_ok ? V_W'(win[cs*3]) : '0)
                     + {1'b0, win[cs*3+1], 1'b0}
                     + (edges.bot_ok ? V_W'(win[cs*3+2]) : '0);
        end
        hsum = (edges.left_ok ? S_W'(vsum[0]) : '0)
             + {1'b0, vsum[1], 1'b0}
             + (edges.right_ok ? S_W'(vsum[2]) : '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= hsum;
        end
    end

    // divide by 3 and 9 via reciprocal multiply, exact over the sum's range
    assign prod3_12 = P_W'(sum_reg >> 2) * P_W'(DIV3_MUL);
    assign prod3_6  = P_W'(sum_reg >> 1) * P_W'(DIV3_MUL);
    assign prod9    = P_W'(sum_reg) * P_W'(DIV9_MUL);

    always_comb begin
        case (code)
            DIV16:   q = sum_reg >> 4;
            DIV12:   q = S_W'(prod3_12 >> DIV3_SH);
            DIV9:    q = S_W'(prod9 >> DIV9_SH);
            DIV8:    q = sum_reg >> 3;
            DIV6:    q = S_W'(prod3_6 >> DIV3_SH);
            DIV4:    q = sum_reg >> 2;
            default: q = sum_reg >> 2;
        endcase
    end

    assign quot = q[CH_W-1:0];

endmodule

// ===== design/binomial_3x3_smoothing_filter.sv =====
// Top level of the 3x3 binomial smoothing filter for RGBA raster streams.
// Path: a released result passes stage B, the window, the lane sum register, then the output register.
// Throughput: one input transfer per cycle while the output side takes results.
// Pipeline: accept + line store read, window update, lane sum, lane divide into output reg.
// Reset (aresetn, synchronous, active low): 640 x 480, counters cleared; the first item clears the window.
// The line stores are not cleared; no clearing pass, the block is ready after reset.
module binomial_3x3_smoothing_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input pixel stream
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [bsf_pkg::CH_W-1:0]       s_red_in,
    input  logic [bsf_pkg::CH_W-1:0]       s_green_in,
    input  logic [bsf_pkg::CH_W-1:0]       s_blue_in,
    input  logic [bsf_pkg::CH_W-1:0]       s_alpha_in,
    // result stream
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bsf_pkg::CH_W-1:0]       m_red_out,
    output logic [bsf_pkg::CH_W-1:0]       m_green_out,
    output logic [bsf_pkg::CH_W-1:0]       m_blue_out,
    output logic [bsf_pkg::CH_W-1:0]       m_alpha_out,
    output logic                           m_frame_end
);
    import bsf_pkg::*;

    // the whole pipeline moves together whenever the output register is free
    logic adv;
    logic s_xfer;
    logic take;
    bsf_item_t item;

    // stage B: item waiting on its line store read
    logic      b_valid_reg;
    bsf_item_t b_item_reg;

    // line store
    logic [2*PIX_W-1:0] ls_rd_data;
    logic [2*PIX_W-1:0] ls_wr_data;
    logic [PIX_W-1:0]   rd_far;
    logic [PIX_W-1:0]   rd_near;

    // stage C: window, slot index = column_slot * 3 + row_slot
    logic [WIN_SIZE-1:0][PIX_W-1:0] win_reg;
    logic                           c_valid_reg;
    logic                           c_last_reg;
    bsf_edge_t                      c_edges_reg;

    // stage D: lane sums registered inside the lanes
    logic               d_valid_reg;
    logic               d_last_reg;
    logic [DIV_W-1:0]   d_code_reg;

    logic [NUM_LANES-1:0][WIN_SIZE-1:0][CH_W-1:0] lane_win;
    logic [NUM_LANES-1:0][CH_W-1:0]               lane_q;

    // output register (merge of the four lanes)
    logic            m_valid_reg;
    logic [CH_W-1:0] m_red_reg;
    logic [CH_W-1:0] m_green_reg;
    logic [CH_W-1:0] m_blue_reg;
    logic [CH_W-1:0] m_alpha_reg;
    logic            m_frame_end_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign s_xfer  = s_valid && adv;

    bsf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_xfer   (s_xfer),
        .opcode    (s_opcode),
        .pix       ({s_alpha_in, s_blue_in, s_green_in, s_red_in}),
        .take      (take),
        .item      (item)
    );

    // far row takes the old near row, near row takes the new pixel
    assign rd_far     = ls_rd_data[2*PIX_W-1:PIX_W];
    assign rd_near    = ls_rd_data[PIX_W-1:0];
    assign ls_wr_data = {rd_near, b_item_reg.pix};

    bsf_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (take),
        .rd_addr (item.col),
        .wr_en   (adv && b_valid_reg),
        .wr_addr (b_item_reg.col),
        .wr_data (ls_wr_data),
        .rd_data (ls_rd_data)
    );

    // stage B
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            b_item_reg <= item;
        end
    end

    // stage C: window shift; a restart flag zeroes the older columns first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg && b_item_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && b_valid_reg) begin
            for (int k = 0; k < 6; k++) begin
                win_reg[k] <= b_item_reg.clr ? '0 : win_reg[k+3];
            end
            win_reg[6]  <= rd_far;
            win_reg[7]  <= rd_near;
            win_reg[8]  <= b_item_reg.pix;
            c_last_reg  <= b_item_reg.last;
            c_edges_reg <= b_item_reg.edges;
        end
    end

    // per-lane view of the window
    always_comb begin
        for (int ch = 0; ch < NUM_LANES; ch++) begin
            for (int k = 0; k < WIN_SIZE; k++) begin
                lane_win[ch][k] = win_reg[k][ch*CH_W +: CH_W];
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bsf_lane u_lane (
            .aclk  (aclk),
            .en    (adv),
            .win   (lane_win[g]),
            .edges (c_edges_reg),
            .code  (d_code_reg),
            .quot  (lane_q[g])
        );
    end

    // stage D control, alongside the lane sum registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_last_reg <= c_last_reg;
            d_code_reg <= div_code(c_edges_reg);
        end
    end

    // output register: merges the lane quotients into one result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && d_valid_reg) begin
            m_red_reg       <= lane_q[0];
            m_green_reg     <= lane_q[1];
            m_blue_reg      <= lane_q[2];
            m_alpha_reg     <= lane_q[3];
            m_frame_end_reg <= d_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_red_reg;
    assign m_green_out = m_green_reg;
    assign m_blue_out  = m_blue_reg;
    assign m_alpha_out = m_alpha_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

// ===== design/bsf_checker.sv =====
// Port-level checks of the smoothing filter, bound to the top level.
module bsf_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [bsf_pkg::CH_W-1:0] m_red_out,
    input logic [bsf_pkg::CH_W-1:0] m_green_out,
    input logic [bsf_pkg::CH_W-1:0] m_blue_out,
    input logic [bsf_pkg::CH_W-1:0] m_alpha_out,
    input logic                     m_frame_end
);
    import bsf_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out)
            && $stable(m_blue_out) && $stable(m_alpha_out) && $stable(m_frame_end))
        else $error("stalled result changed");

    // with the output register empty the input side is never held off
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // input is held off only behind a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind binomial_3x3_smoothing_filter bsf_checker u_bsf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_red_out   (m_red_out),
    .m_green_out (m_green_out),
    .m_blue_out  (m_blue_out),
    .m_alpha_out (m_alpha_out),
    .m_frame_end (m_frame_end)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the 3x3 binomial smoothing filter: directed and random RGBA streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsf_pkg::*;

    // Pixel as it enters: red in the low byte, alpha in the high byte.
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgba_t;

    // One smoothed pixel as it should leave the block.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            frame_end;
    } smoothed_t;

    // Receiver behaviour, picked anew at random whenever the current mode runs out.
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // Register indexes past the end of the list: writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;      // leave a margin over the pipeline depth
    localparam int RANDOM_ITEMS  = 200;
    localparam int PRINT_LIMIT   = 40;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input holds a known value from t=0.
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_opcode  = OP_PIXEL;
    logic [CH_W-1:0]       s_red_in   = '0;
    logic [CH_W-1:0]       s_green_in = '0;
    logic [CH_W-1:0]       s_blue_in  = '0;
    logic [CH_W-1:0]       s_alpha_in = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [CH_W-1:0]       m_red_out;
    logic [CH_W-1:0]       m_green_out;
    logic [CH_W-1:0]       m_blue_out;
    logic [CH_W-1:0]       m_alpha_out;
    logic                  m_frame_end;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    binomial_3x3_smoothing_filter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out),
        .m_frame_end (m_frame_end)
    );

    // ------------------------------------------------------------------
    // Filter predictor: own copy of the registers, line stores and window.
    // Window slot k = column_slot*3 + row_slot; column 0 is left, row 0 above.
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]  img_width_reg;
    logic [HEIGHT_W-1:0] img_height_reg;
    rgba_t               line_near [MAX_WIDTH];
    rgba_t               line_far  [MAX_WIDTH];
    rgba_t               window_px [WIN_SIZE];
    int unsigned         in_col, in_row, out_col, out_row;
    bit                  frame_over;
    smoothed_t           blur_expect_q [$];

    // Run statistics and failure count
    int unsigned items_counted  = 0;
    int unsigned items_ignored  = 0;
    int unsigned results_seen   = 0;
    int unsigned frames_seen    = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    // Sender burst control and the receiver hold-off request
    int unsigned burst_left     = 0;
    bit          gaps_on        = 1'b1;
    int unsigned hold_off_req   = 0;
    int unsigned hold_off_left  = 0;
    int unsigned mode_left      = 0;
    int unsigned rx_tick        = 0;
    rx_mode_t    rx_mode        = RX_OPEN;

    function automatic int unsigned active_width();
        int unsigned w;
        w = img_width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = img_height_reg;
        if (h < 1) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return h;
    endfunction

    // Binomial kernel is separable: (1 2 1) across times (1 2 1) down.
    function automatic int unsigned tap_weight(input int unsigned cs, input int unsigned rs);
        return ((cs == 1) ? 2 : 1) * ((rs == 1) ? 2 : 1);
    endfunction

    function automatic void restart_frame();
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        frame_over = 1'b0;
        foreach (window_px[k]) window_px[k] = '0;
    endfunction

    function automatic void reset_predictor();
        img_width_reg  = RESET_WIDTH;
        img_height_reg = RESET_HEIGHT;
        foreach (line_near[k]) begin
            line_near[k] = '0;
            line_far[k]  = '0;
        end
        restart_frame();
    endfunction

    // Advances the predictor by one accepted transfer; queues a smoothed pixel
    // when one is due. used is low for transfers the block simply drops.
    task automatic predict_transfer(input logic op, input rgba_t px, output bit used);
        int unsigned     w, h, col, sum, wsum, cs, rs, k, ch;
        bit              emit, ok;
        logic [CH_W-1:0] lane_val [NUM_LANES];
        smoothed_t       res;
        w = active_width();
        h = active_height();
        used = 1'b1;
        // once the frame is finished only a pixel (a new frame) gets through
        if (frame_over) begin
            if (op == OP_FLUSH) begin
                used = 1'b0;
                return;
            end
            restart_frame();
        end
        // flush while pixels are still owed: dropped
        if (in_row < h && op == OP_FLUSH) begin
            used = 1'b0;
            return;
        end
        // draining: whatever arrives counts as a blank pixel
        if (in_row >= h) px = '0;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        col = in_col;
        for (k = 0; k < 6; k++) window_px[k] = window_px[k + 3];
        window_px[6]   = line_far[col];
        window_px[7]   = line_near[col];
        window_px[8]   = px;
        line_far[col]  = line_near[col];
        line_near[col] = px;
        emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return;
        for (ch = 0; ch < NUM_LANES; ch++) begin
            sum  = 0;
            wsum = 0;
            for (k = 0; k < WIN_SIZE; k++) begin
                cs = k / 3;
                rs = k % 3;
                // taps outside the image are dropped from sum and divisor alike
                ok = !((cs == 0 && out_col == 0) || (cs == 2 && out_col + 1 >= w) ||
                       (rs == 0 && out_row == 0) || (rs == 2 && out_row + 1 >= h));
                if (ok) begin
                    sum  += tap_weight(cs, rs) * window_px[k][CH_W*ch +: CH_W];
                    wsum += tap_weight(cs, rs);
                end
            end
            lane_val[ch] = CH_W'(sum / wsum);
        end
        res.red       = lane_val[0];
        res.green     = lane_val[1];
        res.blue      = lane_val[2];
        res.alpha     = lane_val[3];
        res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (res.frame_end) frame_over = 1'b1;
        blur_expect_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers. Inputs move on the falling edge, handshakes are
    // judged on the rising edge.
    // ------------------------------------------------------------------
    function automatic rgba_t random_rgba();
        rgba_t p;
        int    k;
        for (k = 0; k < NUM_LANES; k++) begin
            case ($urandom_range(0, 9))
                0:       p[CH_W*k +: CH_W] = '0;
                1:       p[CH_W*k +: CH_W] = '1;
                default: p[CH_W*k +: CH_W] = CH_W'($urandom);
            endcase
        end
        return p;
    endfunction

    // Offers one item and holds it until the transfer; the sender then
    // either carries on with its burst or idles before starting a new burst.
    task automatic send_item(input logic op, input rgba_t px);
        bit used;
        s_valid    = 1'b1;
        s_opcode   = op;
        s_red_in   = px.red;
        s_green_in = px.green;
        s_blue_in  = px.blue;
        s_alpha_in = px.alpha;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_transfer(op, px, used);
        if (used) items_counted++;
        else items_ignored++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            // now and then a long run with no idle cycles at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 24);
        end
    endtask

    task automatic send_frame(input int unsigned n_pixels, input int unsigned n_flushes);
        repeat (n_pixels) send_item(OP_PIXEL, random_rgba());
        repeat (n_flushes) send_item(OP_FLUSH, random_rgba());
    endtask

    // Waits until every queued result has been checked, then lets the
    // pipeline settle so that a trailing no-result item is also done.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (blur_expect_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                img_width_reg = data[WIDTH_W-1:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT: begin
                img_height_reg = data[HEIGHT_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] width_val,
                               input logic [CFG_DATA_W-1:0] height_val);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, width_val);
        write_reg(REG_IMAGE_HEIGHT, height_val);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the block must run 640-wide rows; a row and a bit is
    // enough to see the first results of the top row.
    task automatic test_reset_size();
        send_frame(int'(RESET_WIDTH) + 10, 0);
    endtask

    // Every divisor: 1x1 gives 4, a single column gives 6 and 8, and a 3x3
    // frame gives 9, 12 and 16. Channel values sit at the extremes.
    task automatic test_divisors();
        rgba_t px;
        int    k;
        int    ch;
        reconfigure('0, '0);                    // zero acts as one
        px = '{alpha: 8'h00, blue: 8'hFF, green: 8'h01, red: 8'hFE};
        send_item(OP_PIXEL, px);
        send_frame(0, 2);
        reconfigure(CFG_DATA_W'(1), CFG_DATA_W'(3));
        send_item(OP_PIXEL, '1);
        send_item(OP_PIXEL, '0);
        send_item(OP_PIXEL, '1);
        send_frame(0, 2);
        reconfigure(CFG_DATA_W'(3), CFG_DATA_W'(3));
        for (k = 0; k < 9; k++) begin
            px = '0;
            for (ch = 0; ch < NUM_LANES; ch++)
                if ($urandom_range(0, 1)) px[CH_W*ch +: CH_W] = '1;
            send_item(OP_PIXEL, px);
        end
        send_frame(0, 4);
    endtask

    // Stream rules on a 2x2 frame: stray flushes, a pixel while draining,
    // surplus flushes, back-to-back frames, dead register indexes and a
    // register write that cuts a frame short.
    task automatic test_stream_rules();
        reconfigure(CFG_DATA_W'(2), CFG_DATA_W'(2));
        send_item(OP_FLUSH, random_rgba());     // nothing yet: dropped
        send_frame(2, 0);
        send_item(OP_FLUSH, random_rgba());     // pixels still owed: dropped
        send_frame(2, 0);
        send_item(OP_PIXEL, random_rgba());     // draining: acts as a flush
        send_frame(0, 2);
        send_frame(0, 2);                       // frame over: dropped
        send_frame(4, 3);                       // next frame without a write
        send_frame(3, 0);
        wait_drained();
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        send_frame(1, 3);                       // frame must carry on untouched
        send_frame(3, 0);
        reconfigure(CFG_DATA_W'(2), CFG_DATA_W'(2));  // restart part way through
        send_frame(4, 3);
    endtask

    // Receiver holds off for a long stretch while the sender pushes with
    // no gaps, so the pipeline fills and s_ready must drop.
    task automatic test_output_stall();
        reconfigure(CFG_DATA_W'(12), CFG_DATA_W'(12));
        gaps_on      = 1'b0;
        hold_off_req = 400;
        send_frame(144, 13);
        gaps_on      = 1'b1;
    endtask

    // Mostly well-formed frames of random size and content, with dropped
    // flushes, pixels while draining, surplus flushes and cut-short frames
    // mixed in.
    task automatic test_random_frames();
        int unsigned           goal, w, h, k, stop_at;
        bit                    cut_short;
        logic [CFG_DATA_W-1:0] wr_w, wr_h;
        goal      = items_counted + RANDOM_ITEMS;
        cut_short = 1'b1;                       // always set a size first
        while (items_counted < goal) begin
            case ($urandom_range(0, 19))
                0: begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(20, 48);
                end
                1, 2: begin
                    w = $urandom_range(9, 40);
                    h = $urandom_range(2, 12);
                end
                default: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
            endcase
            if (cut_short || $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 5) == 0) begin
                    wait_drained();
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                              CFG_DATA_W'($urandom));
                end
                wr_w = (w == 1 && $urandom_range(0, 1)) ? '0 : CFG_DATA_W'(w);
                wr_h = (h == 1 && $urandom_range(0, 1)) ? '0 : CFG_DATA_W'(h);
                // top data bit lies outside the width register and is dropped
                if ($urandom_range(0, 3) == 0) wr_w[WIDTH_W] = 1'b1;
                reconfigure(wr_w, wr_h);
            end else begin
                w = active_width();
                h = active_height();
            end
            cut_short = ($urandom_range(0, 11) == 0);
            stop_at   = cut_short ? $urandom_range(0, w * h - 1) : w * h;
            for (k = 0; k < stop_at; k++) begin
                if ($urandom_range(0, 19) == 0) send_item(OP_FLUSH, random_rgba());
                send_item(OP_PIXEL, random_rgba());
            end
            if (!cut_short) begin
                for (k = 0; k <= w; k++)
                    send_item(($urandom_range(0, 6) == 0) ? OP_PIXEL : OP_FLUSH, random_rgba());
                if ($urandom_range(0, 4) == 0)
                    send_frame(0, $urandom_range(1, 3));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus the long hold-off on request.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_off_req != 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left != 0) begin
            m_ready = 1'b0;
            hold_off_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   m_ready = 1'b1;
                RX_COIN:   m_ready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready = ($urandom_range(0, 7) != 0);
                default:   m_ready = (rx_tick % 5) < 2;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transfer against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [CH_W-1:0] want,
                                        input logic [CH_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : check_results
        smoothed_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_red_out, m_green_out, m_blue_out, m_alpha_out, m_frame_end};
            results_seen++;
            if (blur_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t ns: result with nothing expected, expected none, actual %h",
                             $time, got);
            end else begin
                want = blur_expect_q.pop_front();
                if (want.frame_end) frames_seen++;
                check_field("red", want.red, got.red);
                check_field("green", want.green, got.green);
                check_field("blue", want.blue, got.blue);
                check_field("alpha", want.alpha, got.alpha);
                check_field("frame_end", CH_W'(want.frame_end), CH_W'(got.frame_end));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d results still expected", $time,
                     blur_expect_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_predictor();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_size();
        test_divisors();
        test_stream_rules();
        test_output_stall();
        test_random_frames();
        wait_drained();

        $display("Covered %0d input transfers plus %0d dropped ones; %0d smoothed pixels",
                 items_counted, items_ignored, results_seen);
        $display("checked over %0d complete frames of varied size and a row at the reset width.",
                 frames_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
